>>> design/dsw_pkg.sv
// ----------------------------------------------------------------------------
// dsw_pkg
// Shared types and constants for the date string weekday block.
// ----------------------------------------------------------------------------
package dsw_pkg;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_NOEXIST  = 2'd1,
        ST_BAD_FMT  = 2'd2
    } t_status;

    // Parsed date handed from the parser to the evaluator
    typedef struct packed {
        logic        fmt_ok;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
    } t_rec;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] POS_SEP_DAY   = 4'd2;
    localparam logic [3:0] POS_SEP_MONTH = 4'd5;
    localparam logic [3:0] POS_LAST      = 4'd9;
    localparam logic [3:0] POS_END       = 4'd10;
    localparam logic [3:0] POS_MAX       = 4'd15;

endpackage

>>> design/dsw_front.sv
// ----------------------------------------------------------------------------
// dsw_front
// Character parser: checks the format and gathers day, month and year.
// ----------------------------------------------------------------------------
module dsw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char_code,
    input  logic          i_is_last,
    output logic          o_push,
    output dsw_pkg::t_rec o_rec
);
    import dsw_pkg::*;

    logic [3:0]  r_pos,   n_pos;
    logic [6:0]  r_day,   n_day;
    logic [6:0]  r_month, n_month;
    logic [13:0] r_year,  n_year;
    logic        r_fmt,   n_fmt;
    logic        digit;
    logic [3:0]  dv;

    assign digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign dv    = i_char_code[3:0];

    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_fmt   = r_fmt;
        if (r_pos == POS_SEP_DAY || r_pos == POS_SEP_MONTH) begin
            if (i_char_code != CH_SLASH) n_fmt = 1'b0;
        end else if (r_pos < POS_END) begin
            if (!digit) begin
                n_fmt = 1'b0;
            end else if (r_pos < POS_SEP_DAY) begin
                n_day = {r_day[3:0], 3'b000} + {r_day[5:0], 1'b0} + 7'(dv);
            end else if (r_pos < POS_SEP_MONTH) begin
                n_month = {r_month[3:0], 3'b000} + {r_month[5:0], 1'b0} + 7'(dv);
            end else begin
                n_year = {r_year[10:0], 3'b000} + {r_year[12:0], 1'b0} + 14'(dv);
            end
        end else begin
            n_fmt = 1'b0;
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 4'd1;
    end

    assign o_push       = i_accept && i_is_last;
    assign o_rec.fmt_ok = n_fmt && (r_pos == POS_LAST);
    assign o_rec.day    = n_day;
    assign o_rec.month  = n_month;
    assign o_rec.year   = n_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_day   <= '0;
            r_month <= '0;
            r_year  <= '0;
            r_fmt   <= 1'b1;
        end else if (i_accept) begin
            if (i_is_last) begin
                // start over for the next string
                r_pos   <= '0;
                r_day   <= '0;
                r_month <= '0;
                r_year  <= '0;
                r_fmt   <= 1'b1;
            end else begin
                r_pos   <= n_pos;
                r_day   <= n_day;
                r_month <= n_month;
                r_year  <= n_year;
                r_fmt   <= n_fmt;
            end
        end
    end

endmodule

>>> design/dsw_fifo.sv
// ----------------------------------------------------------------------------
// dsw_fifo
// Two-entry queue of parsed dates between parser and evaluator.
// ----------------------------------------------------------------------------
module dsw_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dsw_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output dsw_pkg::t_rec o_rec
);
    import dsw_pkg::*;

    t_rec       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (pop)    r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

endmodule

>>> design/dsw_back.sv
// ----------------------------------------------------------------------------
// dsw_back
// Date evaluator: leap rule, month limits and weekday, three stages.
// ----------------------------------------------------------------------------
module dsw_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dsw_pkg::t_rec i_rec,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_status,
    output logic [2:0]    o_weekday,
    output logic          o_leap_year
);
    import dsw_pkg::*;

    localparam logic [12:0] RECIP_100 = 13'd5243;

    function automatic logic [4:0] month_offset(input logic [3:0] m);
        logic [4:0] v;
        unique case (m)
            4'd1:    v = 5'd2;
            4'd2:    v = 5'd5;
            4'd3:    v = 5'd7;
            4'd4:    v = 5'd10;
            4'd5:    v = 5'd12;
            4'd6:    v = 5'd15;
            4'd7:    v = 5'd17;
            4'd8:    v = 5'd20;
            4'd9:    v = 5'd23;
            4'd10:   v = 5'd25;
            4'd11:   v = 5'd28;
            4'd12:   v = 5'd30;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] month_limit(input logic [6:0] m, input logic is_leap);
        logic [4:0] v;
        unique case (m)
            7'd2:                      v = is_leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:   v = 5'd30;
            default:                   v = 5'd31;
        endcase
        return v;
    endfunction

    // 2^3 = 1 mod 7: fold octal digits
    function automatic logic [2:0] mod7(input logic [14:0] s);
        logic [5:0] g;
        logic [3:0] h;
        g = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
        h = 4'(g[5:3]) + 4'(g[2:0]);
        return (h >= 4'd7) ? 3'(h - 4'd7) : h[2:0];
    endfunction

    logic        r_v1, r_v2, r_vo;
    logic        rdy1, rdy2, rdyo;
    t_rec        r_rec1;
    logic [26:0] r_prod;
    t_status     r_st2;
    logic        r_leap2;
    logic [14:0] r_sum2;
    t_status     r_st_o;
    logic [2:0]  r_wd_o;
    logic        r_leap_o;

    // stage 2 signals
    logic [7:0]  q100;
    logic [13:0] r100;
    logic        rem0;
    logic        leap;
    logic        early;
    logic [11:0] z4;
    logic [7:0]  z100;
    logic [5:0]  z400;
    logic        bad_date;
    t_status     st;
    logic [14:0] sum;

    assign rdyo  = !r_vo || i_ready;
    assign rdy2  = !r_v2 || rdyo;
    assign rdy1  = !r_v1 || rdy2;
    assign o_pop = i_valid && rdy1;

    assign q100  = r_prod[26:19];
    assign r100  = r_rec1.year - 14'(15'(q100) * 15'd100);
    assign rem0  = (r100 == 14'd0);
    assign leap  = rem0 ? (q100[1:0] == 2'b00) : (r_rec1.year[1:0] == 2'b00);
    assign early = (r_rec1.month < 7'd3);

    always_comb begin
        // January and February count against the previous year
        if (early) begin
            z4   = r_rec1.year[13:2] - 12'(r_rec1.year[1:0] == 2'b00);
            z100 = q100 - 8'(rem0);
        end else begin
            z4   = r_rec1.year[13:2];
            z100 = q100;
        end
        z400 = z100[7:2];
        sum = 15'(month_offset(r_rec1.month[3:0])) + 15'(r_rec1.day) + 15'd4
            + 15'(r_rec1.year) + 15'(z4) + 15'(z400) - 15'(z100)
            - (early ? 15'd0 : 15'd2);
        bad_date = (r_rec1.day == 7'd0) || (r_rec1.month == 7'd0)
                || (r_rec1.month > 7'd12) || (r_rec1.year == 14'd0)
                || (r_rec1.day > 7'(month_limit(r_rec1.month, leap)));
        priority if (!r_rec1.fmt_ok) st = ST_BAD_FMT;
        else if (bad_date)           st = ST_NOEXIST;
        else                         st = ST_VALID;
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_rec1 <= i_rec;
            r_prod <= 27'(i_rec.year) * 27'(RECIP_100);
        end
        if (rdy2 && r_v1) begin
            r_st2   <= st;
            r_leap2 <= r_rec1.fmt_ok && leap;
            r_sum2  <= sum;
        end
        if (rdyo && r_v2) begin
            r_st_o   <= r_st2;
            r_leap_o <= r_leap2;
            r_wd_o   <= (r_st2 == ST_VALID) ? mod7(r_sum2) : 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdyo) r_vo <= r_v2;
        end
    end

    assign o_valid     = r_vo;
    assign o_status    = r_st_o;
    assign o_weekday   = r_wd_o;
    assign o_leap_year = r_leap_o;

endmodule

>>> design/date_string_weekday.sv
// ----------------------------------------------------------------------------
// date_string_weekday
// Streaming DD/MM/YYYY checker giving status, weekday and leap flag.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the queue is not full (o_ready high).
// After the last character is accepted, the result passes the queue, the product
// stage, the evaluation stage and the output register before it shows on o_valid.
// The two-entry queue and per-stage valids let parser and evaluator stall apart.
// Reset clears the parser state, the queue and all stage valids.
module date_string_weekday (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [2:0] o_weekday,
    output logic       o_leap_year
);
    import dsw_pkg::*;

    logic accept;
    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_rec rec_in;
    t_rec rec_out;

    assign o_ready = !full;
    assign accept  = i_valid && o_ready;

    dsw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .o_push      (push),
        .o_rec       (rec_in)
    );

    dsw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_rec   (rec_out)
    );

    dsw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_rec       (rec_out),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_weekday   (o_weekday),
        .o_leap_year (o_leap_year)
    );

endmodule

>>> design/dsw_checker.sv
// ----------------------------------------------------------------------------
// dsw_checker
// Port-level checks on the result channel of date_string_weekday.
// ----------------------------------------------------------------------------
module dsw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_status,
    input logic [2:0] o_weekday,
    input logic       o_leap_year
);
    import dsw_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
                                && $stable(o_weekday) && $stable(o_leap_year))
        else $error("stalled result changed");

    a_wd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_VALID) |-> (o_weekday == 3'd0))
        else $error("weekday set on a rejected date");

    a_leap_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_BAD_FMT) |-> !o_leap_year)
        else $error("leap flag set on a bad format");

    a_wd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_VALID) |-> (o_weekday <= 3'd6))
        else $error("weekday out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind date_string_weekday dsw_checker u_dsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_status    (o_status),
    .o_weekday   (o_weekday),
    .o_leap_year (o_leap_year)
);

>>> bench/date_string_weekday_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_string_weekday_chk
// Watches the character and result channels of the date block. Parses the
// accepted characters on its own, predicts status, weekday and leap flag for
// each string, and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module date_string_weekday_chk (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_status,
    input  logic [2:0] i_weekday,
    input  logic       i_leap_year,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_n_valid,
    output int         o_n_noexist,
    output int         o_n_badfmt
);

    typedef struct packed {
        dsw_pkg::t_status status;
        logic [2:0]       wday;
        logic             leap;
    } t_verdict;

    logic [3:0]  pos;
    logic [6:0]  day_acc;
    logic [6:0]  mon_acc;
    logic [13:0] yr_acc;
    logic        fmt_ok;
    t_verdict    verdict_q[$];

    // Judge a well-formed date: existence, leap rule and weekday.
    function automatic t_verdict judge_date(input logic [6:0] d, input logic [6:0] m,
                                            input logic [13:0] y);
        t_verdict v;
        int       lim;
        int       s;
        int       z;
        v.status = dsw_pkg::ST_VALID;
        v.wday   = 3'd0;
        v.leap   = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        case (m)
            7'd2: begin
                lim = v.leap ? 29 : 28;
            end
            7'd4, 7'd6, 7'd9, 7'd11: begin
                lim = 30;
            end
            default: begin
                lim = 31;
            end
        endcase
        if (d == 0 || m == 0 || m > 12 || y == 0 || d > lim) begin
            v.status = dsw_pkg::ST_NOEXIST;
        end else begin
            s = 23 * m / 9 + d + 4 + y;
            // January and February count from the previous year
            if (m < 3) begin
                z = y - 1;
                s = s + z / 4 - z / 100 + z / 400;
            end else begin
                s = s - 2 + y / 4 - y / 100 + y / 400;
            end
            v.wday = 3'(s % 7);
        end
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict want;
        logic [7:0] c;
        if (!i_rst_n) begin
            pos     = 4'd0;
            day_acc = 7'd0;
            mon_acc = 7'd0;
            yr_acc  = 14'd0;
            fmt_ok  = 1'b1;
            verdict_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result: status %0d weekday %0d leap_year %0d",
                           i_status, i_weekday, i_leap_year);
                    o_fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_weekday !== want.wday) begin
                        $error("weekday: expected %0d, got %0d", want.wday, i_weekday);
                        o_fail_count++;
                    end
                    if (i_leap_year !== want.leap) begin
                        $error("leap_year: expected %0d, got %0d", want.leap, i_leap_year);
                        o_fail_count++;
                    end
                    case (want.status)
                        dsw_pkg::ST_VALID: begin
                            o_n_valid++;
                        end
                        dsw_pkg::ST_NOEXIST: begin
                            o_n_noexist++;
                        end
                        default: begin
                            o_n_badfmt++;
                        end
                    endcase
                end
            end
            if (i_in_valid && i_in_ready) begin
                c = i_char_code;
                if (pos == dsw_pkg::POS_SEP_DAY || pos == dsw_pkg::POS_SEP_MONTH) begin
                    if (c != dsw_pkg::CH_SLASH) fmt_ok = 1'b0;
                end else if (pos <= dsw_pkg::POS_LAST) begin
                    if (c < dsw_pkg::CH_ZERO || c > dsw_pkg::CH_NINE) begin
                        fmt_ok = 1'b0;
                    end else if (pos < dsw_pkg::POS_SEP_DAY) begin
                        day_acc = 7'(day_acc * 10 + (c - dsw_pkg::CH_ZERO));
                    end else if (pos < dsw_pkg::POS_SEP_MONTH) begin
                        mon_acc = 7'(mon_acc * 10 + (c - dsw_pkg::CH_ZERO));
                    end else begin
                        yr_acc = 14'(yr_acc * 10 + (c - dsw_pkg::CH_ZERO));
                    end
                end else begin
                    fmt_ok = 1'b0;
                end
                // hold the count once it saturates
                if (pos != dsw_pkg::POS_MAX) pos = pos + 4'd1;
                if (i_is_last) begin
                    if (!fmt_ok || pos != dsw_pkg::POS_END) begin
                        want.status = dsw_pkg::ST_BAD_FMT;
                        want.wday   = 3'd0;
                        want.leap   = 1'b0;
                    end else begin
                        want = judge_date(day_acc, mon_acc, yr_acc);
                    end
                    verdict_q.push_back(want);
                    pos     = 4'd0;
                    day_acc = 7'd0;
                    mon_acc = 7'd0;
                    yr_acc  = 14'd0;
                    fmt_ok  = 1'b1;
                end
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

>>> bench/date_string_weekday_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_string_weekday_tb
// Feeds DD/MM/YYYY strings one character per item into the date block: a
// directed set of edge dates and malformed strings, then random well-formed,
// damaged, truncated, extended and noise strings, with random gaps and
// back-pressure. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module date_string_weekday_tb;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_char_code;
    logic       i_is_last;
    logic       o_valid;
    logic       i_ready;
    logic [1:0] o_status;
    logic [2:0] o_weekday;
    logic       o_leap_year;

    int         fail_count;
    int         pending;
    int         n_valid;
    int         n_noexist;
    int         n_badfmt;
    int         chars_sent;
    int         strings_sent;
    bit         quiet;
    logic [7:0] txt[$];

    date_string_weekday i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_weekday   (o_weekday),
        .o_leap_year (o_leap_year)
    );

    date_string_weekday_chk i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_char_code  (i_char_code),
        .i_is_last    (i_is_last),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_status     (o_status),
        .i_weekday    (o_weekday),
        .i_leap_year  (o_leap_year),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_n_valid    (n_valid),
        .o_n_noexist  (n_noexist),
        .o_n_badfmt   (n_badfmt)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    // Wait cycles before the next item; none at all in quiet stretches.
    function automatic int idle_draw();
        if (quiet) return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 1);
    endfunction

    task automatic load(input string s);
        int k;
        txt.delete();
        for (k = 0; k < s.len(); k++) txt.push_back(s[k]);
    endtask

    task automatic send_text();
        int k;
        int gap;
        for (k = 0; k < txt.size(); k++) begin
            gap = idle_draw();
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_char_code <= txt[k];
            i_is_last   <= (k == txt.size() - 1);
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            chars_sent++;
        end
        strings_sent++;
    endtask

    task automatic send_str(input string s);
        load(s);
        send_text();
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic build_random();
        int kind;
        int d;
        int m;
        int y;
        int n;
        int k;
        kind = $urandom_range(0, 9);
        d = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 31) : $urandom_range(0, 99);
        m = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0: begin
                y = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                                : 100 * $urandom_range(0, 99);
            end
            1: begin
                y = 400 * $urandom_range(0, 24);
            end
            default: begin
                y = $urandom_range(0, 9999);
            end
        endcase
        // lean on the end of February
        if ($urandom_range(0, 7) == 0) begin
            m = 2;
            d = $urandom_range(28, 30);
        end
        txt.delete();
        txt.push_back(8'(dsw_pkg::CH_ZERO + d / 10));
        txt.push_back(8'(dsw_pkg::CH_ZERO + d % 10));
        txt.push_back(dsw_pkg::CH_SLASH);
        txt.push_back(8'(dsw_pkg::CH_ZERO + m / 10));
        txt.push_back(8'(dsw_pkg::CH_ZERO + m % 10));
        txt.push_back(dsw_pkg::CH_SLASH);
        txt.push_back(8'(dsw_pkg::CH_ZERO + y / 1000));
        txt.push_back(8'(dsw_pkg::CH_ZERO + (y / 100) % 10));
        txt.push_back(8'(dsw_pkg::CH_ZERO + (y / 10) % 10));
        txt.push_back(8'(dsw_pkg::CH_ZERO + y % 10));
        case (kind)
            6: begin
                txt[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
            end
            7: begin
                n = $urandom_range(1, 9);
                while (txt.size() > n) void'(txt.pop_back());
            end
            8: begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    txt.push_back(8'(($urandom_range(0, 1) == 0)
                                     ? dsw_pkg::CH_ZERO + $urandom_range(0, 9)
                                     : $urandom_range(0, 255)));
                end
            end
            9: begin
                txt.delete();
                n = $urandom_range(1, 14);
                for (k = 0; k < n; k++) begin
                    case ($urandom_range(0, 3))
                        0: txt.push_back(dsw_pkg::CH_SLASH);
                        1: txt.push_back(8'(dsw_pkg::CH_ZERO + $urandom_range(0, 9)));
                        default: txt.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            default: begin
            end
        endcase
    endtask

    initial begin : sink
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = idle_draw();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : stim
        quiet        = 1'b0;
        chars_sent   = 0;
        strings_sent = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_char_code <= 8'd0;
        i_is_last   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_str("01/01/0001");
        send_str("31/12/9999");
        send_str("29/02/2000");
        send_str("29/02/1900");
        send_str("29/02/2024");
        send_str("30/02/2024");
        send_str("31/04/2023");
        send_str("30/04/2023");
        send_str("00/05/2020");
        send_str("10/00/2020");
        send_str("10/13/2020");
        send_str("99/99/9999");
        send_str("01/01/0000");
        send_str("15/08/1947");
        send_str("1/01/2020");
        send_str("01/01/20200");
        send_str("01-01-2020");
        send_str("0a/01/2020");
        send_str("01/01//020");
        send_str("X");
        send_str("01/01/2020/01/01/20");
        // a NUL byte inside the month and an all-ones byte inside the year
        load("01/01/2020");
        txt[4] = 8'h00;
        send_text();
        load("01/01/2020");
        txt[7] = 8'hFF;
        send_text();
        drain();

        while (chars_sent < 1600) begin
            if (strings_sent % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (strings_sent % 60 == 0) drain();
            build_random();
            send_text();
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d date strings in %0d characters; results seen:", strings_sent,
                 chars_sent);
        $display("  %0d valid dates, %0d nonexistent dates, %0d malformed strings",
                 n_valid, n_noexist, n_badfmt);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
